// ===== hw/rtl/lss_pkg.sv =====
// Shared types, constants and arithmetic helpers of the Laplacian sharpening core.
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

  localparam int unsigned DefMaxWidth  = 2048;
  localparam int unsigned DefMaxHeight = 4096;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgWidthW = 12;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned GainW = 12;
  localparam int unsigned LapW = 11;
  localparam int unsigned ProdW = LapW + GainW;
  localparam int unsigned SumW = ProdW + 1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_GAIN   = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // Red sits in the lowest byte, matching the stream data layout.
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  // Operands of one output pixel.
  typedef struct packed {
    pix_t c;
    pix_t u;
    pix_t d;
    pix_t l;
    pix_t r;
    logic fe;
  } slot_t;

  // Work for one accepted item: one or two output pixels.
  typedef struct packed {
    slot_t s1;
    slot_t s0;
    logic  two;
  } job_t;

  function automatic logic signed [LapW-1:0] lap(input logic [7:0] c, input logic [7:0] u,
                                                 input logic [7:0] d, input logic [7:0] l,
                                                 input logic [7:0] r);
    lap = $signed({1'b0, c, 2'b00}) - $signed({3'b000, u}) - $signed({3'b000, d})
        - $signed({3'b000, l}) - $signed({3'b000, r});
  endfunction

  function automatic logic [7:0] clamp(input logic signed [SumW-1:0] t);
    if (t[SumW-1]) begin
      clamp = 8'd0;
    end else if (|t[SumW-2:16]) begin
      clamp = 8'd255;
    end else begin
      clamp = t[15:8];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lss_front.sv =====
// Front end: accepts pixels and drains, keeps the line buffers and window, builds jobs.
`timescale 1ns / 1ps
`default_nettype none

module lss_front #(
  parameter int unsigned MAX_WIDTH  = lss_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = lss_pkg::DefMaxHeight
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          restart_i,
  input  wire logic [lss_pkg::CfgWidthW-1:0] cfg_width_i,
  input  wire logic [lss_pkg::CfgHeightW-1:0] cfg_height_i,
  input  wire logic                          s_valid_i,
  output logic                               s_ready_o,
  input  wire logic                          s_cmd_i,
  input  wire lss_pkg::pix_t                 s_pix_i,
  input  wire logic [lss_pkg::QueueCntW-1:0] q_count_i,
  output logic                               push_o,
  output lss_pkg::job_t                      job_o
);
  import lss_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCW = $clog2(MAX_HEIGHT + 1);

  logic [WCW-1:0] used_w;
  logic [HCW-1:0] used_h;

  always_comb begin
    if (32'(cfg_width_i) < 32'd2) begin
      used_w = WCW'(2);
    end else if (32'(cfg_width_i) > MAX_WIDTH) begin
      used_w = WCW'(MAX_WIDTH);
    end else begin
      used_w = WCW'(cfg_width_i);
    end
    if (32'(cfg_height_i) < 32'd2) begin
      used_h = HCW'(2);
    end else if (32'(cfg_height_i) > MAX_HEIGHT) begin
      used_h = HCW'(MAX_HEIGHT);
    end else begin
      used_h = HCW'(cfg_height_i);
    end
  end

  logic [AW-1:0]  col_q, col_d, drain_q, drain_d;
  logic [HCW-1:0] row_q, row_d;

  // Stage B registers, filled at acceptance.
  logic          b_valid_q, b_pix_q, b_rowge1_q, b_top_q, b_cge1_q, b_clast_q, b_c1_q;
  logic          b_d0_q, b_dlast_q;
  logic [AW-1:0] b_addr_q;
  pix_t          b_in_q;

  logic accept, is_pix, pix_ok, drn_ok;
  logic [AW-1:0] rd_addr, rd2_addr;

  // Room is reserved for the item already in flight to the queue.
  assign s_ready_o = (32'(q_count_i) + 32'(b_valid_q)) < QueueDepth;
  assign accept    = s_valid_i && s_ready_o;
  assign is_pix    = (s_cmd_i == CMD_PIXEL);
  assign pix_ok    = accept && is_pix && (row_q < used_h);
  assign drn_ok    = accept && !is_pix && (row_q == used_h) && (WCW'(drain_q) < used_w);
  assign rd_addr   = is_pix ? col_q : drain_q;
  assign rd2_addr  = (drain_q == '0) ? AW'(1) : drain_q + AW'(1);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (restart_i) begin
      col_d   = '0;
      row_d   = '0;
      drain_d = '0;
    end else if (pix_ok) begin
      if (WCW'(col_q) + WCW'(1) >= used_w) begin
        col_d = '0;
        row_d = row_q + HCW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end else if (drn_ok) begin
      if (WCW'(drain_q) + WCW'(1) >= used_w) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = '0;
      end else begin
        drain_d = drain_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      drain_q   <= '0;
      b_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      drain_q   <= drain_d;
      b_valid_q <= pix_ok || drn_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    b_pix_q    <= is_pix;
    b_addr_q   <= col_q;
    b_in_q     <= s_pix_i;
    b_rowge1_q <= (row_q != '0);
    b_top_q    <= (row_q == HCW'(1));
    b_cge1_q   <= (col_q != '0);
    b_c1_q     <= (col_q == AW'(1));
    b_clast_q  <= (WCW'(col_q) == used_w - WCW'(1));
    b_d0_q     <= (drain_q == '0);
    b_dlast_q  <= (WCW'(drain_q) == used_w - WCW'(1));
  end

  // Line buffers: middle has two read ports for the drain neighbors.
  pix_t mid_mem [MAX_WIDTH];
  pix_t up_mem  [MAX_WIDTH];
  pix_t mid_rd_q, mid_rd2_q, up_rd_q;

  always_ff @(posedge clk_i) begin
    if (pix_ok) begin
      mid_mem[col_q] <= s_pix_i;
    end
    mid_rd_q  <= mid_mem[rd_addr];
    mid_rd2_q <= mid_mem[rd2_addr];
  end

  // The upper row takes the old middle entry once its read has returned.
  always_ff @(posedge clk_i) begin
    if (b_valid_q && b_pix_q) begin
      up_mem[b_addr_q] <= mid_rd_q;
    end
    up_rd_q <= up_mem[rd_addr];
  end

  pix_t win_q [9];
  pix_t prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (b_valid_q && b_pix_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= up_rd_q;
      win_q[5] <= mid_rd_q;
      win_q[8] <= b_in_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && !b_pix_q) begin
      prev_q <= mid_rd_q;
    end
  end

  // Operands are taken from the window as it stands before this shift.
  always_comb begin
    job_o = '0;
    if (b_pix_q) begin
      push_o       = b_valid_q && b_rowge1_q && b_cge1_q;
      job_o.two    = b_clast_q;
      job_o.s0.c   = win_q[5];
      job_o.s0.u   = b_top_q ? win_q[8] : win_q[2];
      job_o.s0.d   = win_q[8];
      job_o.s0.l   = b_c1_q ? mid_rd_q : win_q[4];
      job_o.s0.r   = mid_rd_q;
      job_o.s0.fe  = 1'b0;
      job_o.s1.c   = mid_rd_q;
      job_o.s1.u   = b_top_q ? b_in_q : up_rd_q;
      job_o.s1.d   = b_in_q;
      job_o.s1.l   = win_q[5];
      job_o.s1.r   = win_q[5];
      job_o.s1.fe  = 1'b0;
    end else begin
      push_o       = b_valid_q;
      job_o.two    = 1'b0;
      job_o.s0.c   = mid_rd_q;
      job_o.s0.u   = up_rd_q;
      job_o.s0.d   = up_rd_q;
      job_o.s0.l   = b_d0_q ? mid_rd2_q : prev_q;
      job_o.s0.r   = b_dlast_q ? prev_q : mid_rd2_q;
      job_o.s0.fe  = b_dlast_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lss_queue.sv =====
// Short job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module lss_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire lss_pkg::job_t                 job_i,
  input  wire logic                          pop_i,
  output lss_pkg::job_t                      head_o,
  output logic                               empty_o,
  output logic [lss_pkg::QueueCntW-1:0]      count_o
);
  import lss_pkg::*;

  localparam int unsigned PW = $clog2(QueueDepth);

  job_t          mem_q [QueueDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (32'(wr_q) == QueueDepth - 1) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (32'(rd_q) == QueueDepth - 1) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lss_back.sv =====
// Back end: Laplacian, gain multiply, floor and clamp, output register.
`timescale 1ns / 1ps
`default_nettype none

module lss_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [lss_pkg::GainW-1:0]  gain_i,
  input  wire lss_pkg::job_t              head_i,
  input  wire logic                       empty_i,
  output logic                            pop_o,
  output logic                            m_valid_o,
  input  wire logic                       m_ready_i,
  output lss_pkg::pix_t                   m_pix_o,
  output logic                            m_fe_o
);
  import lss_pkg::*;

  logic idx_q, m_valid_q, o_valid_q;
  logic out_free, m_move, m_free, issue;
  slot_t slot;
  logic signed [ProdW-1:0] pr_q, pg_q, pb_q;
  pix_t  mc_q;
  logic  mfe_q;

  assign out_free = !o_valid_q || m_ready_i;
  assign m_move   = m_valid_q && out_free;
  assign m_free   = !m_valid_q || out_free;
  assign issue    = !empty_i && m_free;
  assign slot     = idx_q ? head_i.s1 : head_i.s0;
  assign pop_o    = issue && (idx_q || !head_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= 1'b0;
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        idx_q <= !pop_o;
      end
      m_valid_q <= issue || (m_valid_q && !out_free);
      o_valid_q <= m_move || (o_valid_q && !m_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pr_q  <= ProdW'(lap(slot.c.r, slot.u.r, slot.d.r, slot.l.r, slot.r.r))
             * ProdW'($signed(gain_i));
      pg_q  <= ProdW'(lap(slot.c.g, slot.u.g, slot.d.g, slot.l.g, slot.r.g))
             * ProdW'($signed(gain_i));
      pb_q  <= ProdW'(lap(slot.c.b, slot.u.b, slot.d.b, slot.l.b, slot.r.b))
             * ProdW'($signed(gain_i));
      mc_q  <= slot.c;
      mfe_q <= slot.fe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_move) begin
      m_pix_o.r <= clamp($signed({8'b0, mc_q.r, 8'b0}) + SumW'(pr_q));
      m_pix_o.g <= clamp($signed({8'b0, mc_q.g, 8'b0}) + SumW'(pg_q));
      m_pix_o.b <= clamp($signed({8'b0, mc_q.b, 8'b0}) + SumW'(pb_q));
      m_fe_o    <= mfe_q;
    end
  end

  assign m_valid_o = o_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/laplacian_sharpen_3x3_core.sv =====
// Top level of the streaming 3x3 Laplacian sharpening core.
`timescale 1ns / 1ps
`default_nettype none

// Sharpens an RGB raster stream: each channel becomes clamp(orig + gain * L, 0, 255) with L
// the four-neighbor Laplacian, borders reflected without repeating the edge pixel and gain a
// signed Q3.8 value. One item (pixel or drain) is accepted per clock while the queue has
// room; the arithmetic back end delivers one result per clock while the output is not
// stalled, and the item that closes a row yields two results. Pixel (x,y) comes out when
// pixel (x+1,y+1) arrives; the last row is pushed out by one drain request per pixel.
// Writing any register restarts the frame and must only happen while the core is idle.
// Line buffers hold MAX_WIDTH pixels each.
module laplacian_sharpen_3x3_core #(
  parameter int unsigned MAX_WIDTH  = lss_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = lss_pkg::DefMaxHeight
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [lss_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,  // red, green, blue
  input  wire logic [0:0]                   s_axis_tuser,  // command
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // out_red, out_green, out_blue
  output logic                              m_axis_tlast
);
  import lss_pkg::*;

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [GainW-1:0]      gain_q;
  logic                  restart;

  assign restart = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT ||
                                cfg_idx_i == REG_GAIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthW'(640);
      height_q <= CfgHeightW'(480);
      gain_q   <= GainW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i[CfgWidthW-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[CfgHeightW-1:0];
        REG_GAIN:   gain_q   <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  logic                 push, pop, empty;
  job_t                 job, head;
  logic [QueueCntW-1:0] q_count;
  pix_t                 out_pix;

  lss_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .cfg_width_i (width_q),
    .cfg_height_i(height_q),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_cmd_i     (s_axis_tuser[0]),
    .s_pix_i     (s_axis_tdata),
    .q_count_i   (q_count),
    .push_o      (push),
    .job_o       (job)
  );

  lss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .count_o(q_count)
  );

  lss_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .gain_i   (gain_q),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_pix_o  (out_pix),
    .m_fe_o   (m_axis_tlast)
  );

  assign m_axis_tdata = out_pix;

endmodule

`default_nettype wire

// ===== hw/rtl/lss_checker.sv =====
// Port-level checks of the sharpening core, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module lss_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // A stalled result keeps its value and its frame marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Reset empties the output register.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result pending out of reset");

  // Reset empties the queue, so requests are taken at once.
  assert property (@(posedge clk_i) !rst_ni |=> s_axis_tready)
    else $error("input not ready out of reset");

endmodule

bind laplacian_sharpen_3x3_core lss_checker u_lss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
